/* rtl/core/lpc_pkg.sv */
`default_nettype none
package lpc_pkg;

  localparam int ADDR_W     = 48;
  localparam int COUNT_W    = 17;
  localparam int MAXR_W     = 21;
  localparam int SLOT_OUT_W = 3;
  localparam int INPG_OUT_W = 12;
  localparam int COPY_OUT_W = 13;
  localparam int STAMP_W    = 32;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 128;
  localparam int OUT_USED_W = SLOT_OUT_W + 1 + ADDR_W + ADDR_W + INPG_OUT_W + COPY_OUT_W;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAM_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd1;

  typedef enum logic [2:0] {
    LPC_IDLE,
    LPC_CHECK,
    LPC_ERR,
    LPC_LOOK,
    LPC_SCAN,
    LPC_EMIT
  } lpc_state_t;

  typedef struct packed {
    logic load;
    logic look;
    logic scan;
    logic emit;
    logic emit_err;
  } lpc_cmd_t;

  typedef struct packed {
    logic err;
    logic look_hit;
    logic scan_last;
    logic seg_last;
    logic out_free;
  } lpc_stat_t;

endpackage
`default_nettype wire

/* rtl/core/lpc_ctrl.sv */
`default_nettype none
module lpc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpc_pkg::lpc_stat_t  stat,
  output lpc_pkg::lpc_cmd_t   cmd
);
  import lpc_pkg::*;

  lpc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LPC_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      LPC_IDLE:  if (in_valid) state_nxt = LPC_CHECK;
      LPC_CHECK: state_nxt = stat.err ? LPC_ERR : LPC_LOOK;
      LPC_ERR:   if (stat.out_free) state_nxt = LPC_IDLE;
      LPC_LOOK:  state_nxt = stat.look_hit ? LPC_EMIT : LPC_SCAN;
      LPC_SCAN:  if (stat.scan_last) state_nxt = LPC_EMIT;
      LPC_EMIT: begin
        if (stat.out_free) state_nxt = stat.seg_last ? LPC_IDLE : LPC_LOOK;
      end
      default:   state_nxt = LPC_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      LPC_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      LPC_ERR:  cmd.emit_err = stat.out_free;
      LPC_LOOK: cmd.look = 1'b1;
      LPC_SCAN: cmd.scan = 1'b1;
      LPC_EMIT: cmd.emit = stat.out_free;
      default: begin
        in_ready = 1'b0;
        cmd      = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/lpc_dp.sv */
`default_nettype none
module lpc_dp #(
  parameter int SLOTS       = 8,
  parameter int PAGE_BYTES  = 4096,
  parameter int MAX_REQUEST = 65536
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpc_pkg::ADDR_W-1:0]        cfg_data,
  input  logic [lpc_pkg::ADDR_W-1:0]        req_offset,
  input  logic [lpc_pkg::COUNT_W-1:0]       req_count,
  input  lpc_pkg::lpc_cmd_t                 cmd,
  output lpc_pkg::lpc_stat_t                stat,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [lpc_pkg::OUT_DATA_W-1:0]    out_data,
  output logic                              out_last,
  output logic                              out_err
);
  import lpc_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int PAGE_W = $clog2(PAGE_BYTES);
  localparam int ROOM_W = PAGE_W + 1;
  localparam int CMP_W  = (ROOM_W > COUNT_W) ? ROOM_W : COUNT_W;
  localparam int PAD_W  = OUT_DATA_W - OUT_USED_W;

  logic [ADDR_W-1:0]  size_r, base_r;
  logic [ADDR_W-1:0]  cur_r;
  logic [COUNT_W-1:0] left_r;
  logic [ADDR_W-1:0]  tags_r   [SLOTS];
  logic [STAMP_W-1:0] stamps_r [SLOTS];
  logic [STAMP_W-1:0] counter_r;

  logic               hit_r;
  logic [SLOT_W-1:0]  hit_slot_r, victim_r, scan_idx_r;
  logic [STAMP_W-1:0] best_r;
  logic [ADDR_W-1:0]  pbase_r, fill_r;
  logic [PAGE_W-1:0]  inpage_r;
  logic [ROOM_W-1:0]  copy_r;
  logic               seg_last_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r, out_err_r;

  logic [ADDR_W-1:0]  pbase_c;
  logic [PAGE_W-1:0]  inpage_c;
  logic [ROOM_W-1:0]  room_c, copy_c;
  logic               take_room_c;
  logic               hit_any_c;
  logic [SLOT_W-1:0]  hit_idx_c;
  logic [ADDR_W:0]    end_c;
  logic               err_c;
  logic [SLOT_W-1:0]  emit_slot_c;
  logic [STAMP_W-1:0] stamp_nxt;

  assign pbase_c     = {cur_r[ADDR_W-1:PAGE_W], {PAGE_W{1'b0}}};
  assign inpage_c    = cur_r[PAGE_W-1:0];
  assign room_c      = ROOM_W'(PAGE_BYTES) - {1'b0, inpage_c};
  assign take_room_c = CMP_W'(room_c) < CMP_W'(left_r);
  assign copy_c      = take_room_c ? room_c : ROOM_W'(CMP_W'(left_r));

  // tags are unique once installed, so the lowest matching index is the match
  always_comb begin
    hit_any_c = 1'b0;
    hit_idx_c = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (tags_r[i] == pbase_c) begin
        hit_any_c = 1'b1;
        hit_idx_c = SLOT_W'(i);
      end
    end
  end

  // at check time cur_r holds the offset and left_r the count
  assign end_c = {1'b0, cur_r} + (ADDR_W + 1)'(left_r);
  assign err_c = (left_r == '0) || (MAXR_W'(left_r) > MAXR_W'(MAX_REQUEST)) ||
                 (end_c > {1'b0, size_r});

  assign emit_slot_c = hit_r ? hit_slot_r : victim_r;
  assign stamp_nxt   = counter_r + STAMP_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
      base_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STREAM_SIZE:  size_r <= cfg_data;
        CFG_BASE_ADDRESS: base_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        tags_r[i]   <= '1;
        stamps_r[i] <= '0;
      end
      counter_r <= '0;
    end else if (cmd.emit) begin
      if (!hit_r) tags_r[emit_slot_c] <= pbase_r;
      stamps_r[emit_slot_c] <= stamp_nxt;
      counter_r             <= stamp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r  <= req_offset;
      left_r <= req_count;
    end else if (cmd.emit) begin
      cur_r  <= cur_r + ADDR_W'(copy_r);
      left_r <= left_r - COUNT_W'(copy_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      hit_r      <= hit_any_c;
      hit_slot_r <= hit_idx_c;
      pbase_r    <= pbase_c;
      fill_r     <= base_r + pbase_c;
      inpage_r   <= inpage_c;
      copy_r     <= copy_c;
      seg_last_r <= !take_room_c;
      victim_r   <= '0;
      best_r     <= stamps_r[0];
      scan_idx_r <= SLOT_W'(1);
    end else if (cmd.scan) begin
      if (stamps_r[scan_idx_r] < best_r) begin
        victim_r <= scan_idx_r;
        best_r   <= stamps_r[scan_idx_r];
      end
      scan_idx_r <= scan_idx_r + SLOT_W'(1);
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.emit_err) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      out_data_r <= '0;
      out_last_r <= 1'b1;
      out_err_r  <= 1'b1;
    end else if (cmd.emit) begin
      out_data_r <= {{PAD_W{1'b0}}, COPY_OUT_W'(copy_r), INPG_OUT_W'(inpage_r), fill_r,
                     pbase_r, hit_r, SLOT_OUT_W'(emit_slot_c)};
      out_last_r <= seg_last_r;
      out_err_r  <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;
  assign out_err   = out_err_r;

  assign stat.err       = err_c;
  assign stat.look_hit  = hit_any_c;
  assign stat.scan_last = (scan_idx_r == SLOT_W'(SLOTS - 1));
  assign stat.seg_last  = seg_last_r;
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule
`default_nettype wire

/* rtl/core/lru_page_cache_lookup_core.sv */
`default_nettype none
// Page lookup for a fully associative LRU page cache. Each request beat on
// in_ (byte offset, byte count) is checked for a nonzero count of at most
// MAX_REQUEST bytes within the configured stream size and answered either by
// one error beat (tuser set, tlast set, tdata zero) or by one beat per page
// touched, the last one marked by tlast. A request is taken only when the
// block is idle, then goes through the range check, and an error beat follows
// that. Each page segment is a tag compare across all slots, then result and
// stamp update; on a miss a victim search between them walks the use stamps
// one slot per cycle. A result waits in an output register, so a stalled
// out_tready only holds the block once the next result is ready. The tag store
// is set by reset itself, with no clearing pass. Configuration writes are
// always taken and must only be issued while the block is idle.
module lru_page_cache_lookup_core #(
  parameter int SLOTS       = 8,
  parameter int PAGE_BYTES  = 4096,
  parameter int MAX_REQUEST = 65536
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // byte_offset[47:0], byte_count[64:48], zero pad
  input  logic [lpc_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // slot[2:0], hit[3], page_base[51:4], fill_address[99:52],
  // in_page_offset[111:100], copy_bytes[124:112], zero pad
  output logic [lpc_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tlast,
  // error[0]
  output logic                            out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lpc_pkg::ADDR_W-1:0]      cfg_data
);
  import lpc_pkg::*;

  lpc_cmd_t  cmd;
  lpc_stat_t stat;

  assign cfg_ready = 1'b1;

  lpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lpc_dp #(
    .SLOTS       (SLOTS),
    .PAGE_BYTES  (PAGE_BYTES),
    .MAX_REQUEST (MAX_REQUEST)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_offset (in_tdata[ADDR_W-1:0]),
    .req_count  (in_tdata[ADDR_W+COUNT_W-1:ADDR_W]),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_data   (out_tdata),
    .out_last   (out_tlast),
    .out_err    (out_tuser)
  );

endmodule
`default_nettype wire

/* rtl/core/lpc_checker.sv */
`default_nettype none
module lpc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lpc_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                            out_tlast,
  input logic                            out_tuser
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("error beat not marked last");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error beat carries nonzero payload");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

endmodule

bind lru_page_cache_lookup_core lpc_checker u_lpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire

/* test/tb_lru_page_cache_lookup_core.sv */
`timescale 1ns / 100ps
module tb_lru_page_cache_lookup_core;
  import lpc_pkg::*;

  localparam int SLOTS        = 8;
  localparam int PAGE_BYTES   = 4096;
  localparam int MAX_REQUEST  = 65536;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
  localparam int QUIET_LIMIT  = 3000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 50;
  localparam int PRINT_CAP    = 40;

  typedef struct {
    logic [SLOT_OUT_W-1:0] slot;
    logic                  hit;
    logic [ADDR_W-1:0]     page_base;
    logic [ADDR_W-1:0]     fill_address;
    logic [INPG_OUT_W-1:0] in_page_offset;
    logic [COPY_OUT_W-1:0] copy_bytes;
    logic                  last;
    logic                  error;
  } page_seg_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_STREAM_SIZE;
  logic [ADDR_W-1:0]     cfg_data = '0;

  // Shadow of the tag store and registers
  logic [ADDR_W-1:0]  cache_tags [SLOTS];
  logic [STAMP_W-1:0] cache_stamps [SLOTS];
  logic [STAMP_W-1:0] access_count;
  logic [ADDR_W-1:0]  cur_stream_size;
  logic [ADDR_W-1:0]  cur_base_address;
  page_seg_t          segs_due [$];

  bit src_idle_en;
  bit snk_idle_en;
  bit hold_request;
  int hold_left;
  int sink_stall_left;
  int quiet_cycles;
  int mismatches;
  int requests_sent;
  int rejects_due;
  int hits_due;
  int misses_due;
  int results_checked;

  lru_page_cache_lookup_core #(
    .SLOTS(SLOTS),
    .PAGE_BYTES(PAGE_BYTES),
    .MAX_REQUEST(MAX_REQUEST)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[ADDR_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t: %s got 0x%0h want 0x%0h", $time, what, got_v, want_v);
  endtask

  // Split one request into page segments, look each up and queue its result
  task automatic split_and_lookup(input logic [ADDR_W-1:0] off,
                                  input logic [COUNT_W-1:0] cnt);
    logic [63:0] done, pos, pbase, room, left, len;
    int          sl, i;
    bit          found;
    page_seg_t   seg;
    requests_sent++;
    if (cnt == 0 || cnt > MAX_REQUEST || off > cur_stream_size ||
        cnt > cur_stream_size - off) begin
      seg = '{default: '0};
      seg.last = 1'b1;
      seg.error = 1'b1;
      segs_due.push_back(seg);
      rejects_due++;
      return;
    end
    done = 0;
    while (done < cnt) begin
      pos = off + done;
      pbase = pos - (pos % PAGE_BYTES);
      room = PAGE_BYTES - (pos % PAGE_BYTES);
      left = cnt - done;
      len = (room < left) ? room : left;
      found = 1'b0;
      sl = 0;
      for (i = 0; i < SLOTS; i++)
        if (!found && cache_tags[i] == pbase[ADDR_W-1:0]) begin
          found = 1'b1;
          sl = i;
        end
      if (!found) begin
        // victim: oldest stamp, lowest index on ties
        for (i = 1; i < SLOTS; i++)
          if (cache_stamps[i] < cache_stamps[sl]) sl = i;
        cache_tags[sl] = pbase[ADDR_W-1:0];
        misses_due++;
      end else begin
        hits_due++;
      end
      access_count = access_count + 1'b1;
      cache_stamps[sl] = access_count;
      done = done + len;
      seg.slot = SLOT_OUT_W'(sl);
      seg.hit = found;
      seg.page_base = pbase[ADDR_W-1:0];
      seg.fill_address = cur_base_address + pbase[ADDR_W-1:0];
      seg.in_page_offset = INPG_OUT_W'(pos % PAGE_BYTES);
      seg.copy_bytes = COPY_OUT_W'(len);
      seg.last = (done >= cnt);
      seg.error = 1'b0;
      segs_due.push_back(seg);
    end
  endtask

  task automatic send_request(input logic [ADDR_W-1:0] off, input logic [COUNT_W-1:0] cnt);
    int gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {{(IN_DATA_W - ADDR_W - COUNT_W){1'b0}}, cnt, off};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    split_and_lookup(off, cnt);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (segs_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers back to back, valid held across the two beats
  task automatic program_stream(input logic [ADDR_W-1:0] size, input logic [ADDR_W-1:0] base);
    wait_idle();
    cfg_index <= CFG_STREAM_SIZE;
    cfg_data <= size;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cur_stream_size = size;
    cfg_index <= CFG_BASE_ADDRESS;
    cfg_data <= base;
    do @(posedge clk); while (!cfg_ready);
    cur_base_address = base;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_stream();
    program_stream('0, '0);
    send_request('0, '0);
    send_request('0, 17'd1);
    send_request(ADDR_MAX, '1);
  endtask

  task automatic test_config_extremes();
    program_stream(ADDR_MAX, ADDR_MAX);
    send_request('0, 17'd65536);
    send_request(48'd100, 17'd65536);
    send_request('0, 17'd65537);
    send_request(ADDR_MAX - 1'b1, 17'd1);
    send_request(ADDR_MAX, 17'd1);
    send_request(ADDR_MAX - 48'd4095, 17'd4094);
  endtask

  task automatic test_page_edges();
    program_stream(48'd20000, 48'h1234_5678_9abc);
    send_request(48'd4095, 17'd1);
    send_request(48'd4095, 17'd2);
    send_request(48'd4096, 17'd4096);
    send_request(48'd8191, 17'd4097);
    send_request(48'd19990, 17'd10);
    send_request(48'd19990, 17'd11);
    send_request(48'd20000, 17'd1);
    send_request(48'd25000, 17'd1);
  endtask

  // Fill every slot, force one eviction, then touch the oldest pages again
  task automatic test_lru_eviction();
    logic [ADDR_W-1:0] region;
    int k;
    region = 48'h10_0000_0000;
    program_stream(48'h100_0000_0000, rand48());
    for (k = 0; k <= SLOTS; k++)
      send_request(region + ADDR_W'(k * PAGE_BYTES), 17'd1);
    send_request(region, 17'd8192);
  endtask

  task automatic test_output_stall();
    logic [ADDR_W-1:0] region;
    int k;
    region = rand48() >> 1;
    region[11:0] = '0;
    program_stream(ADDR_MAX, rand48());
    src_idle_en = 1'b0;
    hold_request = 1'b1;
    for (k = 0; k < 8; k++)
      send_request(region + ADDR_W'($urandom_range(0, 4 * PAGE_BYTES)),
                   COUNT_W'($urandom_range(PAGE_BYTES, 4 * PAGE_BYTES)));
    wait_idle();
    src_idle_en = 1'b1;
  endtask

  // Mostly reads clustered on a few pages around a hot spot, plus wide random
  // offsets, reads near the stream end and counts that may be illegal
  task automatic test_random_traffic(input logic [ADDR_W-1:0] size,
                                     input logic [ADDR_W-1:0] base, input int n_items);
    logic [63:0]        span, hot;
    logic [ADDR_W-1:0]  off;
    logic [COUNT_W-1:0] cnt;
    int n, pick;
    program_stream(size, base);
    span = {16'd0, size} + 64'd1;
    hot = {16'd0, rand48()} % span;
    hot[11:0] = '0;
    for (n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        off = hot[ADDR_W-1:0] + ADDR_W'($urandom_range(0, 10 * PAGE_BYTES - 1));
        cnt = COUNT_W'($urandom_range(1, 6000));
      end else if (pick < 80) begin
        off = rand48();
        cnt = COUNT_W'($urandom_range(1, MAX_REQUEST));
      end else if (pick < 90) begin
        if (size > 48'd9000) off = size - ADDR_W'($urandom_range(0, 9000));
        else off = ADDR_W'($urandom_range(0, int'(size)));
        cnt = COUNT_W'($urandom_range(1, 9000));
      end else begin
        off = hot[ADDR_W-1:0] + ADDR_W'($urandom_range(0, 10 * PAGE_BYTES - 1));
        cnt = COUNT_W'($urandom_range(0, (1 << COUNT_W) - 1));
      end
      send_request(off, cnt);
    end
  endtask

  // Result side: random stall bursts plus one long hold on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (sink_stall_left > 0) begin
      sink_stall_left--;
      out_tready <= 1'b0;
    end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
      sink_stall_left = $urandom_range(1, 9) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    page_seg_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.slot = out_tdata[2:0];
      got.hit = out_tdata[3];
      got.page_base = out_tdata[51:4];
      got.fill_address = out_tdata[99:52];
      got.in_page_offset = out_tdata[111:100];
      got.copy_bytes = out_tdata[124:112];
      got.last = out_tlast;
      got.error = out_tuser;
      if (segs_due.size() == 0) begin
        report_mismatch("beat with nothing due, page_base", got.page_base, '0);
      end else begin
        want = segs_due.pop_front();
        results_checked++;
        if (got.slot !== want.slot) report_mismatch("slot", got.slot, want.slot);
        if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
        if (got.page_base !== want.page_base)
          report_mismatch("page_base", got.page_base, want.page_base);
        if (got.fill_address !== want.fill_address)
          report_mismatch("fill_address", got.fill_address, want.fill_address);
        if (got.in_page_offset !== want.in_page_offset)
          report_mismatch("in_page_offset", got.in_page_offset, want.in_page_offset);
        if (got.copy_bytes !== want.copy_bytes)
          report_mismatch("copy_bytes", got.copy_bytes, want.copy_bytes);
        if (got.last !== want.last) report_mismatch("last", got.last, want.last);
        if (got.error !== want.error) report_mismatch("error", got.error, want.error);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Timeout: no beat for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, segs_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      cache_tags[i] = '1;
      cache_stamps[i] = '0;
    end
    access_count = '0;
    cur_stream_size = '0;
    cur_base_address = '0;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_stream();
    test_config_extremes();
    test_page_edges();
    test_lru_eviction();
    test_output_stall();
    test_random_traffic(ADDR_MAX, rand48(), 30);
    test_random_traffic(ADDR_W'($urandom_range(1, 300000)), ADDR_MAX, 30);
    test_random_traffic(rand48(), '0, 30);
    test_random_traffic(48'd1, rand48(), 20);
    // closing stretch runs at full rate on both sides
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    test_random_traffic(ADDR_MAX, rand48(), 30);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests (%0d rejected) and %0d page results (%0d hits, %0d misses)",
             requests_sent, rejects_due, results_checked, hits_due, misses_due);
    $display("Stream sizes 0 to 2^48-1, wrapping fill addresses, LRU eviction, long output stall");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
